// File: design/rrc_pkg.sv
// Shared constants for the rounded rectangle pixel coverage block.
// No dependencies; imported by the result and config interfaces, the register file and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

    localparam int CFG_IDX_BITS   = 3;
    localparam int COLOUR_BITS    = 8;
    localparam int ADDR_BITS      = 24;
    localparam int LINE_WIDTH_RST = 320;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_X        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_Y         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_X       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM_Y      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_RADIUS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_COLOUR   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH    = 3'd6;

endpackage

`default_nettype wire

// File: design/rrc_pix_if.sv
// Pixel coordinate channel: valid/ready handshake with x and y.
// Width follows COORD_BITS; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rrc_pix_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// File: design/rrc_res_if.sv
// Coverage result channel: valid/ready handshake with covered flag, colour, address.
// Depends on rrc_pkg for the colour and address widths.
`timescale 1ns / 1ps
`default_nettype none

interface rrc_res_if
    import rrc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   covered;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic [ADDR_BITS-1:0]   pixel_address;

    modport source (output valid, output covered, output pixel_colour,
                    output pixel_address, input ready);
    modport sink   (input valid, input covered, input pixel_colour,
                    input pixel_address, output ready);
endinterface

`default_nettype wire

// File: design/rrc_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on rrc_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface rrc_cfg_if
    import rrc_pkg::*;
#(
    parameter int DATA_BITS = 13
) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/rrc_cfg_regs.sv
// Configuration register file: rectangle edges, radius, colour and line width.
// Depends on rrc_pkg and rrc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module rrc_cfg_regs
    import rrc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    rrc_cfg_if.sink                     i_cfg,
    output logic [COORD_BITS-1:0]       o_left_x,
    output logic [COORD_BITS-1:0]       o_top_y,
    output logic [COORD_BITS-1:0]       o_right_x,
    output logic [COORD_BITS-1:0]       o_bottom_y,
    output logic [COORD_BITS-2:0]       o_corner_radius,
    output logic [COLOUR_BITS-1:0]      o_fill_colour,
    output logic [COORD_BITS:0]         o_line_width
);

    logic [COORD_BITS-1:0]  r_left_x;
    logic [COORD_BITS-1:0]  r_top_y;
    logic [COORD_BITS-1:0]  r_right_x;
    logic [COORD_BITS-1:0]  r_bottom_y;
    logic [COORD_BITS-2:0]  r_corner_radius;
    logic [COLOUR_BITS-1:0] r_fill_colour;
    logic [COORD_BITS:0]    r_line_width;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_x        <= '0;
            r_top_y         <= '0;
            r_right_x       <= '0;
            r_bottom_y      <= '0;
            r_corner_radius <= '0;
            r_fill_colour   <= '0;
            r_line_width    <= (COORD_BITS+1)'(LINE_WIDTH_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEFT_X:        r_left_x        <= i_cfg.data[COORD_BITS-1:0];
                CFG_TOP_Y:         r_top_y         <= i_cfg.data[COORD_BITS-1:0];
                CFG_RIGHT_X:       r_right_x       <= i_cfg.data[COORD_BITS-1:0];
                CFG_BOTTOM_Y:      r_bottom_y      <= i_cfg.data[COORD_BITS-1:0];
                CFG_CORNER_RADIUS: r_corner_radius <= i_cfg.data[COORD_BITS-2:0];
                CFG_FILL_COLOUR:   r_fill_colour   <= i_cfg.data[COLOUR_BITS-1:0];
                CFG_LINE_WIDTH:    r_line_width    <= i_cfg.data[COORD_BITS:0];
                default: begin
                end
            endcase
        end
    end

    assign o_left_x        = r_left_x;
    assign o_top_y         = r_top_y;
    assign o_right_x       = r_right_x;
    assign o_bottom_y      = r_bottom_y;
    assign o_corner_radius = r_corner_radius;
    assign o_fill_colour   = r_fill_colour;
    assign o_line_width    = r_line_width;

endmodule

`default_nettype wire

// File: design/rounded_rect_pixel_coverage.sv
// Rounded rectangle pixel coverage: three-stage pipeline over box and corner disc tests.
// Depends on rrc_pkg, rrc_pix_if, rrc_res_if, rrc_cfg_if and rrc_cfg_regs.
//
// Usage:
//   i_pix  : one pixel (pixel_x, pixel_y) per word, valid/ready.
//   o_res  : one result word per pixel, in order: covered, pixel_colour
//            (fill colour or 0) and pixel_address (y*line_width+x, low 24 bits, or 0).
//   i_cfg  : register writes (index, data), always ready; write only while no
//            pixel is in flight.
//   One pixel per cycle sustained while o_res does not stall.
//   Stage 1 does the edge sums, box compares and corner offsets,
//   stage 2 the squares and the row multiply, stage 3 the disc compares and
//   the address add, and its register drives o_res.
//   A stalled output holds its word; each stage keeps taking words while the
//   stage after it has room, so bubbles are squeezed out and i_pix only backs
//   up once all three stages are full.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (all zero, line width 320).
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_pixel_coverage
    import rrc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrc_pix_if.sink   i_pix,
    rrc_res_if.source o_res,
    rrc_cfg_if.sink   i_cfg
);

    localparam int CW = COORD_BITS;
    localparam int SW = CW + 2;
    localparam int QW = 2 * SW;
    localparam int PW = 2 * CW + 1;
    localparam int AW = (PW + 1 > ADDR_BITS) ? PW + 1 : ADDR_BITS;

    logic [CW-1:0]          cfg_left_x;
    logic [CW-1:0]          cfg_top_y;
    logic [CW-1:0]          cfg_right_x;
    logic [CW-1:0]          cfg_bottom_y;
    logic [CW-2:0]          cfg_radius;
    logic [COLOUR_BITS-1:0] cfg_colour;
    logic [CW:0]            cfg_line_width;

    rrc_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (i_cfg),
        .o_left_x        (cfg_left_x),
        .o_top_y         (cfg_top_y),
        .o_right_x       (cfg_right_x),
        .o_bottom_y      (cfg_bottom_y),
        .o_corner_radius (cfg_radius),
        .o_fill_colour   (cfg_colour),
        .o_line_width    (cfg_line_width)
    );

    // handshake
    logic r_s1_vld, r_s2_vld, r_s3_vld;
    logic rdy_s1, rdy_s2, rdy_s3;

    assign rdy_s3      = !r_s3_vld || o_res.ready;
    assign rdy_s2      = !r_s2_vld || rdy_s3;
    assign rdy_s1      = !r_s1_vld || rdy_s2;
    assign i_pix.ready = rdy_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (rdy_s1) begin
                r_s1_vld <= i_pix.valid;
            end
            if (rdy_s2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (rdy_s3) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    // stage 1: inner edges, box tests, corner offsets
    logic signed [SW-1:0] px_s, py_s, lft_s, top_s, rgt_s, bot_s, rad_s;
    logic signed [SW-1:0] in_l, in_r, in_t, in_b;
    logic                 x_mid, y_mid;
    logic                 n_box;

    assign px_s  = $signed({2'b00, i_pix.pixel_x});
    assign py_s  = $signed({2'b00, i_pix.pixel_y});
    assign lft_s = $signed({2'b00, cfg_left_x});
    assign top_s = $signed({2'b00, cfg_top_y});
    assign rgt_s = $signed({2'b00, cfg_right_x});
    assign bot_s = $signed({2'b00, cfg_bottom_y});
    assign rad_s = $signed({3'b000, cfg_radius});

    assign in_l = lft_s + rad_s;
    assign in_r = rgt_s - rad_s;
    assign in_t = top_s + rad_s;
    assign in_b = bot_s - rad_s;

    assign x_mid = (px_s >= in_l) && (px_s <= in_r);
    assign y_mid = (py_s >= in_t) && (py_s <= in_b);

    assign n_box = (x_mid && y_mid)
                || (x_mid && (py_s >= top_s) && (py_s <= in_t))
                || ((px_s >= in_r) && (px_s <= rgt_s) && y_mid)
                || (x_mid && (py_s >= in_b) && (py_s <= bot_s))
                || ((px_s >= lft_s) && (px_s <= in_l) && y_mid);

    logic                 r_s1_box;
    logic signed [SW-1:0] r_s1_dxl, r_s1_dxr, r_s1_dyt, r_s1_dyb;
    logic [CW-1:0]        r_s1_px, r_s1_py;

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1_box <= n_box;
            r_s1_dxl <= px_s - in_l;
            r_s1_dxr <= px_s - in_r;
            r_s1_dyt <= py_s - in_t;
            r_s1_dyb <= py_s - in_b;
            r_s1_px  <= i_pix.pixel_x;
            r_s1_py  <= i_pix.pixel_y;
        end
    end

    // stage 2: squares and row multiply
    logic                 r_s2_box;
    logic signed [QW-1:0] r_s2_sxl, r_s2_sxr, r_s2_syt, r_s2_syb, r_s2_rsq;
    logic [PW-1:0]        r_s2_row;
    logic [CW-1:0]        r_s2_px;

    always_ff @(posedge i_clk) begin
        if (rdy_s2) begin
            r_s2_box <= r_s1_box;
            r_s2_sxl <= r_s1_dxl * r_s1_dxl;
            r_s2_sxr <= r_s1_dxr * r_s1_dxr;
            r_s2_syt <= r_s1_dyt * r_s1_dyt;
            r_s2_syb <= r_s1_dyb * r_s1_dyb;
            r_s2_rsq <= rad_s * rad_s;
            r_s2_row <= PW'(r_s1_py) * PW'(cfg_line_width);
            r_s2_px  <= r_s1_px;
        end
    end

    // stage 3: disc compares, address, output register
    logic          n_hit;
    logic [AW-1:0] n_addr;

    assign n_hit = r_s2_box
                || (r_s2_sxl + r_s2_syt <= r_s2_rsq)
                || (r_s2_sxr + r_s2_syt <= r_s2_rsq)
                || (r_s2_sxl + r_s2_syb <= r_s2_rsq)
                || (r_s2_sxr + r_s2_syb <= r_s2_rsq);
    assign n_addr = AW'(r_s2_row) + AW'(r_s2_px);

    logic                   r_s3_covered;
    logic [COLOUR_BITS-1:0] r_s3_colour;
    logic [ADDR_BITS-1:0]   r_s3_addr;

    always_ff @(posedge i_clk) begin
        if (rdy_s3) begin
            r_s3_covered <= n_hit;
            r_s3_colour  <= n_hit ? cfg_colour : '0;
            r_s3_addr    <= n_hit ? n_addr[ADDR_BITS-1:0] : '0;
        end
    end

    assign o_res.valid         = r_s3_vld;
    assign o_res.covered       = r_s3_covered;
    assign o_res.pixel_colour  = r_s3_colour;
    assign o_res.pixel_address = r_s3_addr;

endmodule

`default_nettype wire

// File: design/rrc_checker.sv
// Port-level checks for rounded_rect_pixel_coverage, attached with bind.
// Depends on rrc_pkg; sees only the top-level channel signals.
`timescale 1ns / 1ps
`default_nettype none

module rrc_checker
    import rrc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_pix_valid,
    input wire logic                   i_pix_ready,
    input wire logic                   i_res_valid,
    input wire logic                   i_res_ready,
    input wire logic                   i_res_covered,
    input wire logic [COLOUR_BITS-1:0] i_res_colour,
    input wire logic [ADDR_BITS-1:0]   i_res_address
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // uncovered words carry zero colour and address
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_covered) |-> (i_res_colour == '0 && i_res_address == '0))
        else $error("uncovered word with nonzero payload");

    // an accepted word reaches the output while the sink keeps taking words
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_pix_ready) ##1 i_res_ready ##1 i_res_ready |=> i_res_valid)
        else $error("accepted word did not reach the output");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_covered) && $stable(i_res_colour)
             && $stable(i_res_address)))
        else $error("stalled result changed");

endmodule

bind rounded_rect_pixel_coverage rrc_checker u_rrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pix_valid   (i_pix.valid),
    .i_pix_ready   (i_pix.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_covered (o_res.covered),
    .i_res_colour  (o_res.pixel_colour),
    .i_res_address (o_res.pixel_address)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for rounded_rect_pixel_coverage: directed corner, edge and register cases,
// then random rectangles scanned with random source gaps and sink stalls on the data channels.
// Depends on rrc_pkg and the rrc_pix_if, rrc_res_if and rrc_cfg_if interfaces.
`timescale 1ns / 1ps

module testbench;
    import rrc_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int DATA_BITS   = 13;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASES      = 15;
    localparam int PHASE_WORDS = 100;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic                   covered;
        logic [COLOUR_BITS-1:0] colour;
        logic [ADDR_BITS-1:0]   address;
    } t_coverage;

    typedef struct {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-2:0] radius;
        logic [7:0]            colour;
        logic [COORD_BITS:0]   line_width;
    } t_rect_regs;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrc_pix_if #(.COORD_BITS(COORD_BITS)) pix ();
    rrc_res_if                            res ();
    rrc_cfg_if #(.DATA_BITS(DATA_BITS))   cfg ();

    rounded_rect_pixel_coverage #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    t_rect_regs  rect_state;
    t_coverage   expected_coverage[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          pixel_gaps_on;
    bit          result_stalls_on;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_coverage.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit in_box(longint px, longint py, longint x0, longint y0,
                                  longint x1, longint y1);
        return px >= x0 && px <= x1 && py >= y0 && py <= y1;
    endfunction

    function automatic bit in_disc(longint px, longint py, longint cx, longint cy,
                                   longint rad);
        longint dx;
        longint dy;
        dx = px - cx;
        dy = py - cy;
        return dx * dx + dy * dy <= rad * rad;
    endfunction

    function automatic t_coverage predict_coverage(logic [COORD_BITS-1:0] x,
                                                   logic [COORD_BITS-1:0] y);
        longint    px, py, l, t, r, b, rad, il, ir, it, ib, addr;
        bit        hit;
        t_coverage word;
        px  = x;
        py  = y;
        l   = rect_state.left;
        t   = rect_state.top;
        r   = rect_state.right;
        b   = rect_state.bottom;
        rad = rect_state.radius;
        il  = l + rad;
        ir  = r - rad;
        it  = t + rad;
        ib  = b - rad;
        hit = in_box(px, py, il, it, ir, ib) || in_box(px, py, il, t, ir, it)
           || in_box(px, py, ir, it, r, ib)  || in_box(px, py, il, ib, ir, b)
           || in_box(px, py, l, it, il, ib)
           || in_disc(px, py, il, it, rad)   || in_disc(px, py, ir, it, rad)
           || in_disc(px, py, il, ib, rad)   || in_disc(px, py, ir, ib, rad);
        addr = py * longint'(rect_state.line_width) + px;
        word.covered = hit;
        word.colour  = hit ? rect_state.colour : '0;
        word.address = hit ? addr[ADDR_BITS-1:0] : '0;
        return word;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [DATA_BITS-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            CFG_LEFT_X:        rect_state.left       = value[COORD_BITS-1:0];
            CFG_TOP_Y:         rect_state.top        = value[COORD_BITS-1:0];
            CFG_RIGHT_X:       rect_state.right      = value[COORD_BITS-1:0];
            CFG_BOTTOM_Y:      rect_state.bottom     = value[COORD_BITS-1:0];
            CFG_CORNER_RADIUS: rect_state.radius     = value[COORD_BITS-2:0];
            CFG_FILL_COLOUR:   rect_state.colour     = value[7:0];
            CFG_LINE_WIDTH:    rect_state.line_width = value[COORD_BITS:0];
            default: ;
        endcase
    endtask

    // leaves cfg.valid high; config_done closes the burst
    task automatic set_shape(input logic [DATA_BITS-1:0] l, input logic [DATA_BITS-1:0] t,
                             input logic [DATA_BITS-1:0] r, input logic [DATA_BITS-1:0] b,
                             input logic [DATA_BITS-1:0] rad,
                             input logic [DATA_BITS-1:0] colour,
                             input logic [DATA_BITS-1:0] lw);
        write_register(CFG_LEFT_X, l);
        write_register(CFG_TOP_Y, t);
        write_register(CFG_RIGHT_X, r);
        write_register(CFG_BOTTOM_Y, b);
        write_register(CFG_CORNER_RADIUS, rad);
        write_register(CFG_FILL_COLOUR, colour);
        write_register(CFG_LINE_WIDTH, lw);
    endtask

    task automatic config_done();
        cfg.valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        int gap;
        gap = pixel_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        do @(posedge i_clk); while (!pix.ready);
        expected_coverage.push_back(predict_coverage(x, y));
    endtask

    // stop the stream and wait for every result so registers can change
    task automatic finish_stream();
        pix.valid <= 1'b0;
        while (expected_coverage.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        res.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            stall = result_stalls_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin : check_results
        t_coverage want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_coverage.size() == 0) begin
                if (error_count < REPORT_MAX)
                    $display("%0t: unexpected result word covered=%0d colour=%02h addr=%06h",
                             $realtime, res.covered, res.pixel_colour, res.pixel_address);
                error_count++;
            end else begin
                want = expected_coverage.pop_front();
                if (res.covered !== want.covered || res.pixel_colour !== want.colour
                        || res.pixel_address !== want.address) begin
                    if (error_count < REPORT_MAX)
                        $display("%0t: mismatch expected %0d/%02h/%06h got %0d/%02h/%06h",
                                 $realtime, want.covered, want.colour, want.address,
                                 res.covered, res.pixel_colour, res.pixel_address);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'hFFF, 12'hFFF);
        finish_stream();
    endtask

    task automatic test_rounded_corners();
        set_shape(13'd100, 13'd50, 13'd300, 13'd200, 13'd20, 13'hA5, 13'd640);
        config_done();
        send_pixel(12'd100, 12'd50);
        send_pixel(12'd106, 12'd56);
        send_pixel(12'd105, 12'd55);
        send_pixel(12'd100, 12'd70);
        send_pixel(12'd99, 12'd70);
        send_pixel(12'd200, 12'd50);
        send_pixel(12'd300, 12'd180);
        send_pixel(12'd301, 12'd180);
        send_pixel(12'd200, 12'd125);
        finish_stream();
    endtask

    task automatic test_special_shapes();
        // inverted edges: only the discs remain
        set_shape(13'd300, 13'd200, 13'd100, 13'd50, 13'd10, 13'h3C, 13'd320);
        config_done();
        send_pixel(12'd310, 12'd210);
        send_pixel(12'd200, 12'd125);
        finish_stream();
        // zero radius
        set_shape(13'd10, 13'd10, 13'd20, 13'd20, 13'd0, 13'h01, 13'd1);
        config_done();
        send_pixel(12'd10, 12'd10);
        send_pixel(12'd20, 12'd20);
        send_pixel(12'd9, 12'd10);
        finish_stream();
        // radius far beyond the box, line width zero
        set_shape(13'd1000, 13'd1000, 13'd1010, 13'd1010, 13'd2047, 13'hFF, 13'd0);
        config_done();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        finish_stream();
        // full plane, widest line, address wraps; unused index must not disturb anything
        set_shape(13'd0, 13'd0, 13'd4095, 13'd4095, 13'd0, 13'h5A, 13'h1FFF);
        write_register(CFG_UNUSED, 13'h1FFF);
        config_done();
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'h800, 12'h7FF);
        finish_stream();
    endtask

    function automatic logic [COORD_BITS-1:0] near_coord(int a, int c, int rad);
        int lo;
        int hi;
        lo = (a < c ? a : c) - 2 * rad - 3;
        hi = (a > c ? a : c) + 2 * rad + 3;
        if (lo < 0) lo = 0;
        if (hi > COORD_MAX) hi = COORD_MAX;
        return COORD_BITS'($urandom_range(lo, hi));
    endfunction

    task automatic randomize_shape();
        int l, t, r, b, rad, lw, kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            l = 0;
            t = 0;
            r = COORD_MAX;
            b = COORD_MAX;
            rad = $urandom_range(0, 1) ? 2047 : $urandom_range(0, 2047);
        end else if (kind == 1) begin
            l = $urandom_range(60, COORD_MAX);
            r = l - $urandom_range(1, 60);
            t = $urandom_range(60, COORD_MAX);
            b = t - $urandom_range(1, 60);
            rad = $urandom_range(0, 30);
        end else if (kind == 2) begin
            l = $urandom_range(0, 4000);
            r = l + $urandom_range(0, 60);
            t = $urandom_range(0, 4000);
            b = t + $urandom_range(0, 60);
            rad = $urandom_range(30, 300);
        end else begin
            l = $urandom_range(0, 3900);
            r = l + $urandom_range(0, 160);
            t = $urandom_range(0, 3900);
            b = t + $urandom_range(0, 160);
            rad = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 40);
        end
        case ($urandom_range(0, 5))
            0: lw = 0;
            1: lw = 8191;
            2: lw = 4096;
            3: lw = $urandom_range(0, 8191);
            default: lw = $urandom_range(1, 4096);
        endcase
        // spare high data bits must be dropped by the register file
        set_shape({1'($urandom), 12'(l)}, {1'($urandom), 12'(t)},
                  {1'($urandom), 12'(r)}, {1'($urandom), 12'(b)},
                  {2'($urandom), 11'(rad)}, {5'($urandom), 8'($urandom)}, 13'(lw));
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_UNUSED, 13'($urandom));
        config_done();
    endtask

    task automatic test_random_shapes();
        logic [COORD_BITS-1:0] x, y;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: begin pixel_gaps_on = 1'b1; result_stalls_on = 1'b1; end
                1: begin pixel_gaps_on = 1'b0; result_stalls_on = 1'b0; end
                2: begin pixel_gaps_on = 1'b1; result_stalls_on = 1'b0; end
                default: begin pixel_gaps_on = 1'b0; result_stalls_on = 1'b1; end
            endcase
            randomize_shape();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                end else begin
                    x = near_coord(rect_state.left, rect_state.right, rect_state.radius);
                    y = near_coord(rect_state.top, rect_state.bottom, rect_state.radius);
                end
                send_pixel(x, y);
            end
            finish_stream();
        end
    endtask

    initial begin
        rect_state = '{left: '0, top: '0, right: '0, bottom: '0, radius: '0, colour: '0,
                       line_width: (COORD_BITS+1)'(LINE_WIDTH_RST)};
        pixel_gaps_on    = 1'b1;
        result_stalls_on = 1'b1;
        i_rst_n     <= 1'b0;
        pix.valid   <= 1'b0;
        pix.pixel_x <= '0;
        pix.pixel_y <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= '0;
        cfg.data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_rounded_corners();
        test_special_shapes();
        test_random_shapes();

        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_coverage.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
